// File: design/blcd_pkg.sv
// Shared constants, codes and types for the box lasso coordinate descent core.
// Used by the top level, blcd_mul and blcd_div; depends on nothing.
package blcd_pkg;

  localparam int DIM       = 32;
  localparam int FRAC_BITS = 16;

  localparam int IW     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int CW     = $clog2(DIM + 1);
  localparam int QDEPTH = DIM * DIM;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int DCW    = $clog2(FRAC_BITS + 1);
  localparam int MUL_W  = 33;

  localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [63:0] OBJ_MAX = (64'sd1 <<< 47) - 64'sd1;
  localparam logic signed [63:0] OBJ_MIN = -(64'sd1 <<< 47);

  typedef enum logic [1:0] {
    OP_LOAD_Q = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_LOAD_W = 2'd2,
    OP_RUN    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_PENALTY   = 2'd0,
    CFG_MAX_SWEEP = 2'd1,
    CFG_THRESHOLD = 2'd2,
    CFG_DIM       = 2'd3
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_WAIT,
    ST_DOT_RD,
    ST_DOT_MUL,
    ST_DOT_ACC,
    ST_UPD_RES,
    ST_UPD_CMP,
    ST_UPD_DIV,
    ST_OBJ_INIT,
    ST_OBJ_RD,
    ST_OBJ_MUL,
    ST_OBJ_ACC,
    ST_OBJ_WB_RD,
    ST_OBJ_WB_CAP,
    ST_OBJ_LIN,
    ST_OBJ_QHI,
    ST_OBJ_QSUM,
    ST_PEN_LO,
    ST_PEN_HI,
    ST_PEN_SUM,
    ST_CONV,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  // Floor shift of a full 64-bit product back to fixed point.
  function automatic logic signed [63:0] fx_shift(input logic [63:0] p);
    fx_shift = $signed(p) >>> FRAC_BITS;
  endfunction

endpackage

// File: design/box_lasso_coordinate_descent_core.sv
// Top level of the box lasso coordinate descent core: sequencer and datapath.
// Depends on blcd_pkg, blcd_ram, blcd_mul and blcd_div.
//
// Usage: an item is transferred when start is high and busy is low. Load items
// (Q entry, b entry, start weight) are written in that cycle, so loads can
// follow one per cycle and busy never rises for them. A run item raises busy
// and performs sweeps of coordinate descent followed by an objective pass.
// All products come from one registered 33x33 multiplier and all quotients
// from one bit-serial divider under the sequencer. After the last sweep the
// n weights come out one after another, each on the result ports for one
// cycle with done high; last marks the final one, and busy falls in that
// same cycle. The receiver cannot stall results. Configuration writes
// (cfg_write, cfg_index, cfg_data) take effect at once and are meant for
// idle periods. Synchronous reset clears the sequencer and sets the
// configuration registers to their defaults; the stores hold nothing defined
// until they are written.
module box_lasso_coordinate_descent_core
  import blcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation,
  input  logic [5:0]          row_index,
  input  logic [5:0]          col_index,
  input  logic signed [31:0]  value,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                done,
  output logic [5:0]          weight_index,
  output logic signed [17:0]  weight_value,
  output logic                last,
  output logic [10:0]         sweeps_done,
  output logic                zero_diagonal
);

  state_t state, state_next;

  logic [30:0]        sparsity_penalty;
  logic [9:0]         max_sweeps;
  logic signed [31:0] converge_threshold;
  logic [6:0]         dim_in_use;

  logic [CW-1:0]      n, i, j;
  logic [10:0]        sweeps;
  logic               zdiag;
  logic signed [31:0] wi, bi, qii;
  logic signed [63:0] acc, quad, lin, l1, s_res, qtmp;
  logic signed [47:0] obj, prev_obj;

  logic               accept;
  logic               last_i, last_j, j_is_i;
  logic [CW-1:0]      n_clamp;

  logic               q_we, b_we, w_we;
  logic [QAW-1:0]     q_waddr, q_raddr, q_diag, q_ij;
  logic [IW-1:0]      w_waddr, w_raddr;
  logic [31:0]        w_wdata, q_rd, b_rd, w_rd;
  logic               row_ok, col_ok;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  logic                 div_start, div_done;
  logic [FRAC_BITS-1:0] div_q;

  logic [63:0]        ms;
  logic [31:0]        mq;
  logic               neg, big;
  logic signed [63:0] r_res, pen64, full, obj_raw;
  logic signed [48:0] change;

  assign busy          = state != ST_IDLE;
  assign accept        = start && !busy;
  assign sweeps_done   = sweeps;
  assign zero_diagonal = zdiag;

  assign last_i = CW'(i + 1'b1) == n;
  assign last_j = CW'(j + 1'b1) == n;
  assign j_is_i = j == i;

  assign row_ok = {1'b0, row_index} < 7'(DIM);
  assign col_ok = {1'b0, col_index} < 7'(DIM);

  always_comb begin
    if (dim_in_use == 7'd0) begin
      n_clamp = CW'(1);
    end else if (dim_in_use > 7'(DIM)) begin
      n_clamp = CW'(DIM);
    end else begin
      n_clamp = CW'(dim_in_use);
    end
  end

  assign q_diag = QAW'(i[IW-1:0]) * QAW'(DIM) + QAW'(i[IW-1:0]);
  assign q_ij   = QAW'(i[IW-1:0]) * QAW'(DIM) + QAW'(j[IW-1:0]);

  // Update arithmetic: thresholded residual and its magnitude against |Q_ii|.
  assign pen64 = $signed({33'd0, sparsity_penalty});
  assign r_res = 64'(bi) - acc;
  assign ms    = s_res[63] ? 64'(-s_res) : 64'(s_res);
  assign mq    = qii[31] ? 32'(-qii) : 32'(qii);
  assign neg   = s_res[63] != qii[31];
  assign big   = ms >= {32'd0, mq};

  assign full    = qtmp + $signed({mul_p[31:0], 32'd0});
  assign obj_raw = (quad >>> 1) - lin + fx_shift(full);
  assign change  = 49'(obj) - 49'(prev_obj);

  blcd_ram #(.WIDTH(32), .DEPTH(QDEPTH)) u_q_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(value),
    .raddr(q_raddr), .rdata(q_rd)
  );

  blcd_ram #(.WIDTH(32), .DEPTH(DIM)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(row_index[IW-1:0]), .wdata(value),
    .raddr(i[IW-1:0]), .rdata(b_rd)
  );

  blcd_ram #(.WIDTH(32), .DEPTH(DIM)) u_w_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rd)
  );

  blcd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  blcd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(ms[31:0]),
    .divisor(mq), .quotient(div_q), .done(div_done)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (accept && operation == OP_RUN) state_next = ST_CHK_RD;
      ST_CHK_RD:     state_next = ST_CHK_WAIT;
      ST_CHK_WAIT: begin
        if (w_rd != 32'd0) begin
          state_next = ST_DOT_RD;
        end else begin
          state_next = last_i ? ST_OBJ_INIT : ST_CHK_RD;
        end
      end
      ST_DOT_RD:     state_next = ST_DOT_MUL;
      ST_DOT_MUL: begin
        if (j_is_i) begin
          state_next = last_j ? ST_UPD_RES : ST_DOT_RD;
        end else begin
          state_next = ST_DOT_ACC;
        end
      end
      ST_DOT_ACC:    state_next = last_j ? ST_UPD_RES : ST_DOT_RD;
      ST_UPD_RES:    state_next = ST_UPD_CMP;
      ST_UPD_CMP: begin
        if (qii == 32'sd0 || big) begin
          state_next = last_i ? ST_OBJ_INIT : ST_CHK_RD;
        end else begin
          state_next = ST_UPD_DIV;
        end
      end
      ST_UPD_DIV:    if (div_done) state_next = last_i ? ST_OBJ_INIT : ST_CHK_RD;
      ST_OBJ_INIT:   state_next = ST_OBJ_RD;
      ST_OBJ_RD:     state_next = ST_OBJ_MUL;
      ST_OBJ_MUL:    state_next = ST_OBJ_ACC;
      ST_OBJ_ACC:    state_next = last_j ? ST_OBJ_WB_RD : ST_OBJ_RD;
      ST_OBJ_WB_RD:  state_next = ST_OBJ_WB_CAP;
      ST_OBJ_WB_CAP: state_next = ST_OBJ_LIN;
      ST_OBJ_LIN:    state_next = ST_OBJ_QHI;
      ST_OBJ_QHI:    state_next = ST_OBJ_QSUM;
      ST_OBJ_QSUM:   state_next = last_i ? ST_PEN_LO : ST_OBJ_RD;
      ST_PEN_LO:     state_next = ST_PEN_HI;
      ST_PEN_HI:     state_next = ST_PEN_SUM;
      ST_PEN_SUM:    state_next = ST_CONV;
      ST_CONV: begin
        if (sweeps <= {1'b0, max_sweeps} && change > 49'(converge_threshold)) begin
          state_next = ST_CHK_RD;
        end else begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD:    state_next = ST_EMIT_OUT;
      ST_EMIT_OUT:   state_next = last_i ? ST_IDLE : ST_EMIT_RD;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Memory ports, multiplier operands and divider launch.
  always_comb begin
    q_we      = accept && operation == OP_LOAD_Q && row_ok && col_ok;
    b_we      = accept && operation == OP_LOAD_B && row_ok;
    q_waddr   = QAW'(row_index[IW-1:0]) * QAW'(DIM) + QAW'(col_index[IW-1:0]);
    q_raddr   = (state == ST_CHK_RD) ? q_diag : q_ij;
    w_raddr   = (state == ST_DOT_RD || state == ST_OBJ_RD) ? j[IW-1:0] : i[IW-1:0];
    w_we      = 1'b0;
    w_waddr   = i[IW-1:0];
    w_wdata   = 32'd0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      ST_IDLE: begin
        w_we    = accept && operation == OP_LOAD_W && row_ok;
        w_waddr = row_index[IW-1:0];
        w_wdata = value;
      end
      ST_DOT_MUL, ST_OBJ_MUL: begin
        mul_a = MUL_W'($signed(q_rd));
        mul_b = MUL_W'($signed(w_rd));
      end
      ST_UPD_CMP: begin
        if (qii == 32'sd0) begin
          w_we = 1'b1;
        end else if (big) begin
          w_we    = 1'b1;
          w_wdata = neg ? 32'(-ONE_FX) : ONE_FX;
        end else begin
          div_start = 1'b1;
        end
      end
      ST_UPD_DIV: begin
        w_we    = div_done;
        w_wdata = neg ? 32'(-{{(32-FRAC_BITS){1'b0}}, div_q})
                      : {{(32-FRAC_BITS){1'b0}}, div_q};
      end
      ST_OBJ_WB_CAP: begin
        mul_a = MUL_W'($signed(b_rd));
        mul_b = MUL_W'($signed(w_rd));
      end
      ST_OBJ_LIN: begin
        mul_a = MUL_W'(wi);
        mul_b = $signed({1'b0, acc[31:0]});
      end
      ST_OBJ_QHI: begin
        mul_a = MUL_W'(wi);
        mul_b = MUL_W'($signed(acc[63:32]));
      end
      ST_PEN_LO: begin
        mul_a = $signed({2'b00, sparsity_penalty});
        mul_b = $signed({1'b0, l1[31:0]});
      end
      ST_PEN_HI: begin
        mul_a = $signed({2'b00, sparsity_penalty});
        mul_b = MUL_W'($signed(l1[63:32]));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      sparsity_penalty   <= '0;
      max_sweeps         <= 10'd100;
      converge_threshold <= 32'sd1;
      dim_in_use         <= 7'd32;
      done               <= 1'b0;
      n                  <= CW'(1);
      i                  <= '0;
      j                  <= '0;
      sweeps             <= '0;
      zdiag              <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_t'(cfg_index))
          CFG_PENALTY:   sparsity_penalty   <= cfg_data[30:0];
          CFG_MAX_SWEEP: max_sweeps         <= cfg_data[9:0];
          CFG_THRESHOLD: converge_threshold <= $signed(cfg_data);
          CFG_DIM:       dim_in_use         <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && operation == OP_RUN) begin
            n      <= n_clamp;
            i      <= '0;
            sweeps <= '0;
            zdiag  <= 1'b0;
          end
        end
        ST_CHK_WAIT: begin
          j <= '0;
          if (w_rd == 32'd0) i <= CW'(i + 1'b1);
        end
        ST_DOT_MUL:  if (j_is_i) j <= CW'(j + 1'b1);
        ST_DOT_ACC:  j <= CW'(j + 1'b1);
        ST_UPD_CMP: begin
          if (qii == 32'sd0) zdiag <= 1'b1;
          if (qii == 32'sd0 || big) i <= CW'(i + 1'b1);
        end
        ST_UPD_DIV:  if (div_done) i <= CW'(i + 1'b1);
        ST_OBJ_INIT: begin
          i      <= '0;
          j      <= '0;
          sweeps <= sweeps + 1'b1;
        end
        ST_OBJ_ACC:  j <= CW'(j + 1'b1);
        ST_OBJ_QSUM: begin
          j <= '0;
          i <= CW'(i + 1'b1);
        end
        ST_CONV:     i <= '0;
        ST_EMIT_OUT: begin
          done <= 1'b1;
          i    <= CW'(i + 1'b1);
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers; the sequencer decides when each one loads.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE:      prev_obj <= '0;
      ST_CHK_WAIT: begin
        wi  <= $signed(w_rd);
        bi  <= $signed(b_rd);
        qii <= $signed(q_rd);
        acc <= '0;
      end
      ST_DOT_ACC:   acc <= acc + fx_shift(mul_p[63:0]);
      ST_UPD_RES: begin
        if (r_res > pen64) begin
          s_res <= r_res - pen64;
        end else if (r_res < -pen64) begin
          s_res <= r_res + pen64;
        end else begin
          s_res <= '0;
        end
      end
      ST_OBJ_INIT: begin
        acc  <= '0;
        quad <= '0;
        lin  <= '0;
        l1   <= '0;
      end
      ST_OBJ_ACC:   acc <= acc + fx_shift(mul_p[63:0]);
      ST_OBJ_WB_CAP: begin
        wi <= $signed(w_rd);
        l1 <= l1 + (w_rd[31] ? -64'($signed(w_rd)) : 64'($signed(w_rd)));
      end
      ST_OBJ_LIN:   lin <= lin + fx_shift(mul_p[63:0]);
      ST_OBJ_QHI:   qtmp <= mul_p[63:0];
      ST_OBJ_QSUM: begin
        quad <= quad + fx_shift(full);
        acc  <= '0;
      end
      ST_PEN_HI:    qtmp <= mul_p[63:0];
      ST_PEN_SUM: begin
        if (obj_raw > OBJ_MAX) begin
          obj <= OBJ_MAX[47:0];
        end else if (obj_raw < OBJ_MIN) begin
          obj <= OBJ_MIN[47:0];
        end else begin
          obj <= obj_raw[47:0];
        end
      end
      ST_CONV:      prev_obj <= obj;
      ST_EMIT_OUT: begin
        weight_index <= 6'(i);
        weight_value <= $signed(w_rd[17:0]);
        last         <= last_i;
      end
      default: begin
      end
    endcase
  end

  // A run ends with its final result, and only a run raises busy.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    done && last |-> !busy)
    else $error("final result shown while the block is still busy");

  a_busy_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && operation == OP_RUN))
    else $error("busy rose without a run transfer");

  a_div_in_update: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_UPD_DIV)
    else $error("divider finished outside the weight update");

endmodule

// File: design/blcd_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; used for the Q matrix, b vector and weight stores.
module blcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/blcd_mul.sv
// Shared signed multiplier with a registered product.
// Depends on blcd_pkg for the operand width.
module blcd_mul
  import blcd_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_W-1:0]   a,
  input  logic signed [MUL_W-1:0]   b,
  output logic signed [2*MUL_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: design/blcd_div.sv
// Restoring divider for the weight magnitude, one quotient bit per cycle.
// Dividend is below the divisor, so FRAC_BITS steps give the whole quotient.
// Depends on blcd_pkg.
module blcd_div
  import blcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          dividend,
  input  logic [31:0]          divisor,
  output logic [FRAC_BITS-1:0] quotient,
  output logic                 done
);

  logic [31:0]    rem;
  logic [31:0]    dvs;
  logic [DCW-1:0] cnt;
  logic           active;
  logic [32:0]    shifted;
  logic           take;

  assign shifted = {rem, 1'b0};
  assign take    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= DCW'(FRAC_BITS);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dvs      <= divisor;
      quotient <= '0;
    end else if (active) begin
      rem      <= take ? 32'(shifted - {1'b0, dvs}) : shifted[31:0];
      quotient <= {quotient[FRAC_BITS-2:0], take};
    end
  end

endmodule
